// File: sv/imp_pkg.sv
// ----------------------------------------------------------------------------
// imp_pkg: shared types and codes for the indexed max priority table
// Operation and status codes, beat structs and the front-to-back request.
// ----------------------------------------------------------------------------
package imp_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_RAISE  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] entry_id;
    logic [15:0] amount;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top_id;
  } out_beat_t;

  // request passed from front to back: decoded op plus payload
  typedef struct packed {
    op_e         op;
    logic [31:0] entry_id;
    logic [15:0] amount;
  } req_t;

endpackage

// File: sv/imp_ram.sv
// ----------------------------------------------------------------------------
// imp_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module imp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: sv/imp_front.sv
// ----------------------------------------------------------------------------
// imp_front: input stage and request queue
// Classifies incoming beats and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module imp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  imp_pkg::in_beat_t  in_i,
  output logic               full_o,
  output logic               req_valid_o,
  output imp_pkg::req_t      req_o,
  input  logic               req_take_i
);

  imp_pkg::req_t slot_q [2];
  logic          rd_ptr_q, wr_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;
  imp_pkg::req_t req_in;

  always_comb begin
    req_in.op       = imp_pkg::op_e'(in_i.operation);
    req_in.entry_id = in_i.entry_id;
    req_in.amount   = in_i.amount;
  end

  assign full_o      = cnt_q[1];
  assign do_push     = push_i && !full_o;
  assign req_valid_o = cnt_q != 2'd0;
  assign do_pop      = req_take_i && req_valid_o;
  assign req_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("request queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !do_pop) |=> full_o)
    else $error("queue lost full state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && do_push) |=> req_valid_o)
    else $error("pushed beat not visible");

endmodule

// File: sv/imp_back.sv
// ----------------------------------------------------------------------------
// imp_back: table engine
// Scans the slot memories one entry per cycle to find the id, a free slot
// and the top entry, then applies the operation and emits the result beat.
// ----------------------------------------------------------------------------
module imp_back #(
  parameter int Capacity  = 64,
  parameter int LevelBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  imp_pkg::req_t      req_i,
  output logic               req_take_o,
  output logic               empty_o,
  output imp_pkg::out_beat_t out_o,
  input  logic               pop_i
);

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);
  localparam logic [LevelBits-1:0] LevelMax = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_APPLY, S_RESULT
  } state_e;

  state_e                state_q;
  imp_pkg::req_t         req_q;
  logic [CW-1:0]         idx_q;
  logic [AW-1:0]         rd_slot_q;
  logic                  rd_vld_q;
  logic [Capacity-1:0]   valid_q;
  logic                  found_q, free_ok_q, best_ok_q;
  logic [AW-1:0]         found_idx_q, free_idx_q;
  logic [31:0]           best_id_q, best_arr_q, arrival_q;
  logic [LevelBits-1:0]  best_lvl_q, found_lvl_q;
  logic                  out_vld_q;
  imp_pkg::out_beat_t    out_q;

  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [31:0]           id_wd, id_rd, arr_wd, arr_rd;
  logic [LevelBits-1:0]  lvl_wd, lvl_rd, raised;
  logic [LevelBits:0]    sum;
  logic                  better;

  imp_ram #(.Width(32), .Depth(Capacity)) u_id (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(id_wd), .rdata_o(id_rd));
  imp_ram #(.Width(LevelBits), .Depth(Capacity)) u_lvl (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(lvl_wd), .rdata_o(lvl_rd));
  imp_ram #(.Width(32), .Depth(Capacity)) u_arr (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(arr_wd), .rdata_o(arr_rd));

  assign sum    = {1'b0, found_lvl_q} + {{(LevelBits-16){1'b0}}, 1'b0, req_q.amount};
  assign raised = sum[LevelBits] ? LevelMax : sum[LevelBits-1:0];
  assign better = !best_ok_q || lvl_rd > best_lvl_q ||
                  (lvl_rd == best_lvl_q && arr_rd < best_arr_q);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = idx_q[AW-1:0];
    id_wd    = req_q.entry_id;
    lvl_wd   = {{(LevelBits-16){1'b0}}, req_q.amount};
    arr_wd   = arrival_q;
    if (state_q == S_APPLY) begin
      if (req_q.op == imp_pkg::OP_INSERT && !found_q && free_ok_q) begin
        mem_we   = 1'b1;
        mem_addr = free_idx_q;
      end else if (req_q.op == imp_pkg::OP_RAISE && found_q) begin
        mem_addr = found_idx_q;
        mem_we   = 1'b0;
      end
    end
    if (state_q == S_RESULT && req_q.op == imp_pkg::OP_RAISE && found_q) begin
      mem_we   = 1'b1;
      mem_addr = found_idx_q;
      id_wd    = id_rd;
      lvl_wd   = raised;
      arr_wd   = arr_rd;
    end
  end

  assign req_take_o = state_q == S_IDLE && !out_vld_q;
  assign empty_o    = !out_vld_q;
  assign out_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_take_o && req_valid_i) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      arrival_q   <= '0;
      out_vld_q   <= 1'b0;
      idx_q       <= '0;
      rd_slot_q   <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      best_ok_q   <= 1'b0;
      found_idx_q <= '0;
      free_idx_q  <= '0;
      best_id_q   <= '0;
      best_arr_q  <= '0;
      best_lvl_q  <= '0;
      found_lvl_q <= '0;
      out_q       <= '0;
    end else begin
      if (out_vld_q && pop_i) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_take_o && req_valid_i) begin
            idx_q     <= '0;
            rd_vld_q  <= 1'b0;
            found_q   <= 1'b0;
            free_ok_q <= 1'b0;
            best_ok_q <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (rd_vld_q) begin
            if (valid_q[rd_slot_q]) begin
              if (!found_q && id_rd == req_q.entry_id) begin
                found_q     <= 1'b1;
                found_idx_q <= rd_slot_q;
                found_lvl_q <= lvl_rd;
              end
              if (better) begin
                best_ok_q  <= 1'b1;
                best_id_q  <= id_rd;
                best_lvl_q <= lvl_rd;
                best_arr_q <= arr_rd;
              end
            end else if (!free_ok_q) begin
              free_ok_q  <= 1'b1;
              free_idx_q <= rd_slot_q;
            end
          end
          if (state_q == S_LAST) begin
            state_q <= S_APPLY;
          end else begin
            rd_slot_q <= idx_q[AW-1:0];
            rd_vld_q  <= 1'b1;
            if (idx_q == CW'(Capacity - 1)) state_q <= S_LAST;
            else idx_q <= idx_q + 1'b1;
          end
        end
        S_APPLY: begin
          out_q.top_id <= '0;
          out_q.status <= imp_pkg::ST_OK;
          case (req_q.op)
            imp_pkg::OP_INSERT: begin
              if (found_q) out_q.status <= imp_pkg::ST_DUPLICATE;
              else if (!free_ok_q) out_q.status <= imp_pkg::ST_FULL;
              else begin
                valid_q[free_idx_q] <= 1'b1;
                arrival_q <= arrival_q + 32'd1;
              end
            end
            imp_pkg::OP_RAISE: begin
              if (!found_q) out_q.status <= imp_pkg::ST_NOT_FOUND;
            end
            imp_pkg::OP_REMOVE: begin
              if (!found_q) out_q.status <= imp_pkg::ST_NOT_FOUND;
              else valid_q[found_idx_q] <= 1'b0;
            end
            default: begin
              if (!best_ok_q) out_q.status <= imp_pkg::ST_EMPTY;
              else out_q.top_id <= best_id_q;
            end
          endcase
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          out_vld_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT) |=> out_vld_q)
    else $error("result beat not produced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take_o |-> (state_q == S_IDLE))
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && pop_i) |=> !out_vld_q)
    else $error("popped result beat not released");

endmodule

// File: sv/indexed_max_priority_table.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_table: keyed max priority table
// Usage: write a command beat (insert / raise / remove / query) with push
// while full is low. A front stage queues up to two commands; the back
// engine runs one command at a time and scans all CAPACITY slots, one slot
// per cycle through registered-read RAMs, finding the id, the lowest free
// slot and the top entry (highest level, then earliest insert) together.
// Each command yields exactly one result beat (status, top_id), shown while
// empty is low and taken with pop.
// After the scan the engine steps through S_LAST, S_APPLY and S_RESULT
// before the result beat shows. The engine waits for the result to be
// popped before it takes the next command from the front queue.
// Reset clears valid flags, arrival counter, the front queue and the
// result beat; no clearing pass is needed. While the result is not popped,
// the engine holds and the front queue fills, then full rises.
// ----------------------------------------------------------------------------
module indexed_max_priority_table #(
  parameter int CAPACITY   = 64,
  parameter int LEVEL_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  imp_pkg::in_beat_t  in_beat_i,
  output logic               empty,
  input  logic               pop,
  output imp_pkg::out_beat_t out_beat_o
);

  logic          req_valid, req_take;
  imp_pkg::req_t req;

  imp_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .in_i(in_beat_i), .full_o(full),
    .req_valid_o(req_valid), .req_o(req), .req_take_i(req_take));

  imp_back #(.Capacity(CAPACITY), .LevelBits(LEVEL_BITS)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_i(req), .req_take_o(req_take),
    .empty_o(empty), .out_o(out_beat_o), .pop_i(pop));

endmodule
